// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the debouncer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/bdph_pkg.sv -----
// Types and constants of the button debouncer with press and hold detection
package bdph_pkg;

   localparam int unsigned CsrAddrWidth = 4;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE_LIMIT = 2'd0,
      CSR_STALE_CLEAR    = 2'd1,
      CSR_HOLD_TIME      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_WAIT   = 2'd0,
      MODE_IDLE   = 2'd1,
      MODE_ACTIVE = 2'd2,
      MODE_HELD   = 2'd3
   } mode_type;

   localparam logic [7:0]  DebounceLimitReset = 8'd5;
   localparam logic [15:0] StaleClearReset    = 16'd500;
   localparam logic [15:0] HoldTimeReset      = 16'd2000;

   typedef struct packed {
      logic [7:0]  debounce_limit;
      logic [15:0] stale_clear_ms;
      logic [15:0] hold_time_ms;
   } cfg_type;

   typedef struct packed {
      logic        button_active;
      logic [31:0] now_ms;
      logic        ack_pressed;
      logic        ack_held;
   } item_type;

   typedef struct packed {
      logic     pressed_flag;
      logic     held_flag;
      mode_type debounce_mode;
   } result_type;

endpackage

// ----- hw/rtl/bdph_if.sv -----
// Valid/ready channel interfaces for button samples and debouncer results
interface bdph_req_if;
   logic        valid;
   logic        ready;
   logic        button_active;
   logic [31:0] now_ms;
   logic        ack_pressed;
   logic        ack_held;

   modport source (
      output valid, button_active, now_ms, ack_pressed, ack_held,
      input  ready
   );
   modport sink (
      input  valid, button_active, now_ms, ack_pressed, ack_held,
      output ready
   );
endinterface

interface bdph_rsp_if;
   logic       valid;
   logic       ready;
   logic       pressed_flag;
   logic       held_flag;
   logic [1:0] debounce_mode;

   modport source (
      output valid, pressed_flag, held_flag, debounce_mode,
      input  ready
   );
   modport sink (
      input  valid, pressed_flag, held_flag, debounce_mode,
      output ready
   );
endinterface

// ----- hw/rtl/button_debounce_press_hold_unit.sv -----
// Top level: input register, debounce state machine, result register, APB registers
// An accepted transaction passes through the input register, then the result register, to rsp.
// Throughput: one transaction per cycle while rsp is not stalled.
// A stalled rsp holds one result while one more transaction waits in the input register.
// Reset (synchronous, active high) empties both registers, sets mode to waiting
// for idle, clears count, flags and start time, and loads register defaults.
module button_debounce_press_hold_unit (
   input  logic                               clock,
   input  logic                               reset,
   bdph_req_if.sink                           req,
   bdph_rsp_if.source                         rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bdph_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import bdph_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type result;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff && !advance;
      if (req.valid && req.ready) begin
         in_valid_in           = 1'b1;
         item_in.button_active = req.button_active;
         item_in.now_ms        = req.now_ms;
         item_in.ack_pressed   = req.ack_pressed;
         item_in.ack_held      = req.ack_held;
      end
   end

   assign rsp_in       = advance ? result : rsp_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   bdph_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bdph_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.pressed_flag  = rsp_ff.pressed_flag;
   assign rsp.held_flag     = rsp_ff.held_flag;
   assign rsp.debounce_mode = rsp_ff.debounce_mode;

endmodule

// ----- hw/rtl/bdph_csr.sv -----
// APB configuration registers of the debouncer
`include "assert_macros.svh"

module bdph_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bdph_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output bdph_pkg::cfg_type                  cfg
);
   import bdph_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   csr_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            CSR_DEBOUNCE_LIMIT: cfg_in.debounce_limit = csr_pwdata[7:0];
            CSR_STALE_CLEAR:    cfg_in.stale_clear_ms = csr_pwdata[15:0];
            CSR_HOLD_TIME:      cfg_in.hold_time_ms   = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_DEBOUNCE_LIMIT: csr_prdata = {24'd0, cfg_ff.debounce_limit};
         CSR_STALE_CLEAR:    csr_prdata = {16'd0, cfg_ff.stale_clear_ms};
         CSR_HOLD_TIME:      csr_prdata = {16'd0, cfg_ff.hold_time_ms};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_limit <= DebounceLimitReset;
         cfg_ff.stale_clear_ms <= StaleClearReset;
         cfg_ff.hold_time_ms   <= HoldTimeReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   `ASSERT_NEXT(a_limit_write, clock, reset, wr_en && idx == CSR_DEBOUNCE_LIMIT,
      cfg_ff.debounce_limit == $past(csr_pwdata[7:0]))

endmodule

// ----- hw/rtl/bdph_fsm.sv -----
// Debounce state machine: mode, start timestamp, count and sticky flags
`include "assert_macros.svh"

module bdph_fsm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  bdph_pkg::item_type     item,
   input  bdph_pkg::cfg_type      cfg,
   output bdph_pkg::result_type   result
);
   import bdph_pkg::*;

   mode_type    mode_ff,    mode_in;
   logic [31:0] start_ff,   start_in;
   logic [7:0]  count_ff,   count_in;
   logic        pressed_ff, pressed_in;
   logic        held_ff,    held_in;

   logic [31:0] age;
   logic [7:0]  count_inc;
   logic        past_limit;
   mode_type    mode_nx;
   logic [7:0]  count_nx;
   logic        pressed_nx;
   logic        held_nx;

   assign age        = item.now_ms - start_ff;
   assign count_inc  = count_ff + 8'd1;
   assign past_limit = count_inc > cfg.debounce_limit;

   always_comb begin
      mode_nx    = mode_ff;
      count_nx   = count_ff;
      pressed_nx = pressed_ff;
      held_nx    = held_ff;
      case (mode_ff)
         MODE_IDLE: begin
            if (age > {16'd0, cfg.stale_clear_ms}) begin
               pressed_nx = 1'b0;
               held_nx    = 1'b0;
            end
            if (item.button_active) begin
               count_nx = count_inc;
               if (past_limit) mode_nx = MODE_ACTIVE;
            end
         end
         MODE_ACTIVE: begin
            if (item.button_active) begin
               count_nx = 8'd0;
               if (age > {16'd0, cfg.hold_time_ms}) begin
                  mode_nx = MODE_HELD;
                  held_nx = 1'b1;
               end
            end else begin
               count_nx = count_inc;
               if (past_limit) begin
                  mode_nx    = MODE_IDLE;
                  pressed_nx = 1'b1;
               end
            end
         end
         MODE_HELD: begin
            if (item.button_active) begin
               count_nx = 8'd0;
            end else begin
               count_nx = count_inc;
               if (past_limit) mode_nx = MODE_IDLE;
            end
         end
         default: begin
            pressed_nx = 1'b0;
            held_nx    = 1'b0;
            if (!item.button_active) begin
               count_nx = count_inc;
               if (past_limit) mode_nx = MODE_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      start_in   = start_ff;
      count_in   = count_ff;
      pressed_in = pressed_ff;
      held_in    = held_ff;
      if (step_en) begin
         mode_in    = mode_nx;
         count_in   = (mode_nx != mode_ff) ? 8'd0 : count_nx;
         start_in   = (mode_nx != mode_ff) ? item.now_ms : start_ff;
         pressed_in = pressed_nx && !item.ack_pressed;
         held_in    = held_nx && !item.ack_held;
      end
   end

   assign result.pressed_flag  = pressed_nx;
   assign result.held_flag     = held_nx;
   assign result.debounce_mode = mode_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_WAIT;
         start_ff   <= 32'd0;
         count_ff   <= 8'd0;
         pressed_ff <= 1'b0;
         held_ff    <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         start_ff   <= start_in;
         count_ff   <= count_in;
         pressed_ff <= pressed_in;
         held_ff    <= held_in;
      end
   end

   `ASSERT_IMPLY(a_held_rise_in_held, clock, reset, $rose(held_ff), mode_ff == MODE_HELD)
   `ASSERT_IMPLY(a_press_rise_in_idle, clock, reset, $rose(pressed_ff), mode_ff == MODE_IDLE)
   `ASSERT_IMPLY(a_mode_change_clears, clock, reset, mode_ff != $past(mode_ff),
      count_ff == 8'd0 && start_ff == $past(item.now_ms))

endmodule
